[rtl/core/brs_pkg.sv]
// Shared types and constants for the bilinear image resampler.
// Depends on nothing; every other file in rtl/core but brs_div imports it.
`default_nettype none

package brs_pkg;

    // Default sizes of the source frame store and the fixed-point format.
    localparam int DEF_MAX_SRC_ROWS = 256;
    localparam int DEF_MAX_SRC_COLS = 256;
    localparam int DEF_FRAC_BITS    = 16;

    // Field widths.
    localparam int SRC_SIZE_W = 9;
    localparam int DST_SIZE_W = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int CHAN_W     = 8;
    localparam int LOAD_IDX_W = 8;
    localparam int REQ_IDX_W  = 12;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE     = 3'd4;

    // Register values after reset.
    localparam logic [SRC_SIZE_W-1:0] RST_SRC_SIZE = 9'd256;
    localparam logic [DST_SIZE_W-1:0] RST_DST_SIZE = 13'd256;

    // Item kinds.
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_PRODUCE = 1'b1;

    // Input word: a pixel load or an output pixel request.
    typedef struct packed {
        logic                  kind;
        logic [LOAD_IDX_W-1:0] src_row;
        logic [LOAD_IDX_W-1:0] src_col;
        logic [CHAN_W-1:0]     in_blue;
        logic [CHAN_W-1:0]     in_green;
        logic [CHAN_W-1:0]     in_red;
        logic [REQ_IDX_W-1:0]  out_row;
        logic [REQ_IDX_W-1:0]  out_col;
    } t_in_word;

    // Output word: one interpolated pixel.
    typedef struct packed {
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
    } t_out_word;

endpackage

`default_nettype wire

[rtl/core/brs_in_if.sv]
// Valid/ready channel carrying input words into the resampler.
// Depends on brs_pkg for the word type.
`default_nettype none

interface brs_in_if import brs_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/brs_out_if.sv]
// Valid/ready channel carrying output pixels out of the resampler.
// Depends on brs_pkg for the word type.
`default_nettype none

interface brs_out_if import brs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/brs_div.sv]
// Restoring divider, one quotient bit per cycle, used to compute the steps.
// Standalone; no package dependency.
`default_nettype none

module brs_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [NUM_W-1:0] o_quot,
    output logic                  o_busy
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             qbit;
    logic [DEN_W-1:0] n_rem;

    // Shift the next dividend bit into the remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    // Control: count down the quotient bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: the dividend register fills up with quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], qbit};
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_num;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

[rtl/core/bilinear_image_resampler_top.sv]
// Top level of the bilinear image resampler: frame store, step dividers, pipeline.
// Depends on brs_pkg, brs_in_if, brs_out_if and brs_div.
//
// Usage:
// The input channel carries two kinds of word. A load word writes one BGR
// pixel into the source frame store and gives no result. A produce word asks
// for one pixel of the resized image and gives exactly one output word, the
// bilinear blend of four source pixels, in request order.
// The frame store is split into four banks by row and column parity, so the
// four neighbors of a pixel are read in the same cycle.
// Throughput is one word per cycle while the dividers are idle and the
// receiver is ready. A produce word is registered in turn by the capture,
// position, index, bank and sum stages; loads are written from the index stage.
// After reset, and after any write of a size register, the row and column
// steps are recomputed by two bit-serial dividers; the input is not ready
// while they run. Frame store contents are undefined after reset until
// written.
// When the receiver stalls, the output word holds and the pipeline keeps
// taking input until every stage is full, then ready drops.
`default_nettype none

module bilinear_image_resampler_top import brs_pkg::*; #(
    parameter int MAX_SRC_ROWS = DEF_MAX_SRC_ROWS,
    parameter int MAX_SRC_COLS = DEF_MAX_SRC_COLS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    brs_in_if.sink                     i_in,
    brs_out_if.source                  o_out
);

    // Derived widths.
    localparam int RW   = ($clog2(MAX_SRC_ROWS) < 2) ? 2 : $clog2(MAX_SRC_ROWS);
    localparam int CW   = ($clog2(MAX_SRC_COLS) < 2) ? 2 : $clog2(MAX_SRC_COLS);
    localparam int RSW  = RW + FRAC_BITS;
    localparam int CSW  = CW + FRAC_BITS;
    localparam int OW   = DST_SIZE_W;
    localparam int PRW  = OW + RSW;
    localparam int PCW  = OW + CSW;
    localparam int RIW  = OW + RW;
    localparam int CIW  = OW + CW;
    localparam int WW   = FRAC_BITS + 1;
    localparam int AW   = (RW - 1) + (CW - 1);
    localparam int BANK_DEPTH = 1 << AW;
    localparam int SW   = CHAN_W + WW + 2;
    localparam int PIX_W = 3 * CHAN_W;

    localparam logic [WW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [SRC_SIZE_W-1:0] r_src_width;
    logic [SRC_SIZE_W-1:0] r_src_height;
    logic [DST_SIZE_W-1:0] r_dst_width;
    logic [DST_SIZE_W-1:0] r_dst_height;
    logic                  r_rotate;
    logic                  r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SRC_SIZE;
            r_src_height <= RST_SRC_SIZE;
            r_dst_width  <= RST_DST_SIZE;
            r_dst_height <= RST_DST_SIZE;
            r_rotate     <= 1'b0;
            r_start      <= 1'b1;
        end else begin
            r_start <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SRC_WIDTH: begin
                        r_src_width <= i_cfg_data[SRC_SIZE_W-1:0];
                        r_start     <= 1'b1;
                    end
                    CFG_SRC_HEIGHT: begin
                        r_src_height <= i_cfg_data[SRC_SIZE_W-1:0];
                        r_start      <= 1'b1;
                    end
                    CFG_DST_WIDTH: begin
                        r_dst_width <= i_cfg_data[DST_SIZE_W-1:0];
                        r_start     <= 1'b1;
                    end
                    CFG_DST_HEIGHT: begin
                        r_dst_height <= i_cfg_data[DST_SIZE_W-1:0];
                        r_start      <= 1'b1;
                    end
                    CFG_ROTATE: begin
                        r_rotate <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Last valid source row and column, with sizes saturated into range.
    logic [31:0]           sh32, sw32, hm1_32, wm1_32;
    logic [RW-1:0]         hm1;
    logic [CW-1:0]         wm1;
    logic [DST_SIZE_W-1:0] dh, dw;

    always_comb begin
        sh32 = 32'(r_src_height);
        sw32 = 32'(r_src_width);
        if (sh32 == 32'd0) begin
            hm1_32 = 32'd0;
        end else if (sh32 > 32'(MAX_SRC_ROWS)) begin
            hm1_32 = 32'(MAX_SRC_ROWS - 1);
        end else begin
            hm1_32 = sh32 - 32'd1;
        end
        if (sw32 == 32'd0) begin
            wm1_32 = 32'd0;
        end else if (sw32 > 32'(MAX_SRC_COLS)) begin
            wm1_32 = 32'(MAX_SRC_COLS - 1);
        end else begin
            wm1_32 = sw32 - 32'd1;
        end
        hm1 = hm1_32[RW-1:0];
        wm1 = wm1_32[CW-1:0];
        dh  = (r_dst_height == '0) ? DST_SIZE_W'(1) : r_dst_height;
        dw  = (r_dst_width == '0) ? DST_SIZE_W'(1) : r_dst_width;
    end

    // Step dividers.
    logic [RSW-1:0] row_step;
    logic [CSW-1:0] col_step;
    logic           row_busy, col_busy, busy;

    brs_div #(.NUM_W(RSW), .DEN_W(DST_SIZE_W)) u_row_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   ({hm1, {FRAC_BITS{1'b0}}}),
        .i_den   (dh),
        .o_quot  (row_step),
        .o_busy  (row_busy)
    );

    brs_div #(.NUM_W(CSW), .DEN_W(DST_SIZE_W)) u_col_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_num   ({wm1, {FRAC_BITS{1'b0}}}),
        .i_den   (dw),
        .o_quot  (col_step),
        .o_busy  (col_busy)
    );

    assign busy = r_start || row_busy || col_busy;

    // ------------------------------------------------------------------
    // Pipeline handshake: a stage moves when the next one is empty or moves.
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic adv1, adv2, adv3, adv4, adv5, accept;

    assign adv5   = !r5_v || o_out.ready;
    assign adv4   = !r4_v || adv5;
    assign adv3   = !r3_v || adv4;
    assign adv2   = !r2_v || adv3;
    assign adv1   = !r1_v || adv2;
    assign i_in.ready = adv1 && !busy;
    assign accept = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // Stage 1: capture the word, apply the half turn to the request when rotation is on.
    logic [OW-1:0]  in_orow, in_ocol, n_orow, n_ocol;
    logic [31:0]    lrow32, lcol32;
    logic           in_lok;

    always_comb begin
        in_orow = OW'(i_in.data.out_row);
        in_ocol = OW'(i_in.data.out_col);
        if (r_rotate) begin
            n_orow = (in_orow >= dh) ? '0 : dh - 1'b1 - in_orow;
            n_ocol = (in_ocol >= dw) ? '0 : dw - 1'b1 - in_ocol;
        end else begin
            n_orow = in_orow;
            n_ocol = in_ocol;
        end
        lrow32 = 32'(i_in.data.src_row);
        lcol32 = 32'(i_in.data.src_col);
        in_lok = (lrow32 < 32'(MAX_SRC_ROWS)) && (lcol32 < 32'(MAX_SRC_COLS));
    end

    logic             r1_kind, r1_lok;
    logic [RW-1:0]    r1_lrow;
    logic [CW-1:0]    r1_lcol;
    logic [PIX_W-1:0] r1_pix;
    logic [OW-1:0]    r1_orow, r1_ocol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv1) begin
            r1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r1_kind <= i_in.data.kind;
            r1_lok  <= in_lok;
            r1_lrow <= lrow32[RW-1:0];
            r1_lcol <= lcol32[CW-1:0];
            r1_pix  <= {i_in.data.in_red, i_in.data.in_green, i_in.data.in_blue};
            r1_orow <= n_orow;
            r1_ocol <= n_ocol;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: source positions in fixed point.
    logic             r2_kind, r2_lok;
    logic [RW-1:0]    r2_lrow;
    logic [CW-1:0]    r2_lcol;
    logic [PIX_W-1:0] r2_pix;
    logic [PRW-1:0]   r2_prow;
    logic [PCW-1:0]   r2_pcol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_kind <= r1_kind;
            r2_lok  <= r1_lok;
            r2_lrow <= r1_lrow;
            r2_lcol <= r1_lcol;
            r2_pix  <= r1_pix;
            r2_prow <= PRW'(r1_orow) * PRW'(row_step);
            r2_pcol <= PCW'(r1_ocol) * PCW'(col_step);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: neighbor indexes with edge clamping, and the four weights.
    logic [RIW-1:0]       r0i, hm1x;
    logic [RIW:0]         r1i;
    logic [CIW-1:0]       c0i, wm1x;
    logic [CIW:0]         c1i;
    logic [RW-1:0]        n_r0, n_r1;
    logic [CW-1:0]        n_c0, n_c1;
    logic [FRAC_BITS-1:0] fr, fc;
    logic [WW-1:0]        omfr, omfc;
    logic [2*WW-1:0]      p00, p01, p10, p11;

    always_comb begin
        r0i  = r2_prow[PRW-1:FRAC_BITS];
        c0i  = r2_pcol[PCW-1:FRAC_BITS];
        r1i  = {1'b0, r0i} + 1'b1;
        c1i  = {1'b0, c0i} + 1'b1;
        hm1x = RIW'(hm1);
        wm1x = CIW'(wm1);
        n_r0 = (r0i > hm1x) ? hm1 : r0i[RW-1:0];
        n_r1 = (r1i > {1'b0, hm1x}) ? hm1 : r1i[RW-1:0];
        n_c0 = (c0i > wm1x) ? wm1 : c0i[CW-1:0];
        n_c1 = (c1i > {1'b0, wm1x}) ? wm1 : c1i[CW-1:0];
        fr   = r2_prow[FRAC_BITS-1:0];
        fc   = r2_pcol[FRAC_BITS-1:0];
        omfr = ONE - {1'b0, fr};
        omfc = ONE - {1'b0, fc};
        p00  = omfr * omfc;
        p01  = omfr * {1'b0, fc};
        p10  = {1'b0, fr} * omfc;
        p11  = {1'b0, fr} * {1'b0, fc};
    end

    logic             r3_kind, r3_lok;
    logic [RW-1:0]    r3_lrow, r3_r0, r3_r1;
    logic [CW-1:0]    r3_lcol, r3_c0, r3_c1;
    logic [PIX_W-1:0] r3_pix;
    logic [WW-1:0]    r3_w00, r3_w01, r3_w10, r3_w11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_kind <= r2_kind;
            r3_lok  <= r2_lok;
            r3_lrow <= r2_lrow;
            r3_lcol <= r2_lcol;
            r3_pix  <= r2_pix;
            r3_r0   <= n_r0;
            r3_r1   <= n_r1;
            r3_c0   <= n_c0;
            r3_c1   <= n_c1;
            r3_w00  <= p00[FRAC_BITS+WW-1:FRAC_BITS];
            r3_w01  <= p01[FRAC_BITS+WW-1:FRAC_BITS];
            r3_w10  <= p10[FRAC_BITS+WW-1:FRAC_BITS];
            r3_w11  <= p11[FRAC_BITS+WW-1:FRAC_BITS];
        end
    end

    // ------------------------------------------------------------------
    // Frame store: four banks by row parity and column parity. Loads write
    // and requests read in the same stage, so accesses stay in item order.
    logic [RW-1:0]    row_for_par [2];
    logic [CW-1:0]    col_for_par [2];
    logic [PIX_W-1:0] r_bank_q [4];
    logic [1:0]       load_bank;
    logic [AW-1:0]    load_addr;
    logic             load_we;

    always_comb begin
        row_for_par[0] = (r3_r0[0] == 1'b0) ? r3_r0 : r3_r1;
        row_for_par[1] = (r3_r0[0] == 1'b1) ? r3_r0 : r3_r1;
        col_for_par[0] = (r3_c0[0] == 1'b0) ? r3_c0 : r3_c1;
        col_for_par[1] = (r3_c0[0] == 1'b1) ? r3_c0 : r3_c1;
        load_bank = {r3_lrow[0], r3_lcol[0]};
        load_addr = {r3_lrow[RW-1:1], r3_lcol[CW-1:1]};
        load_we   = r3_v && (r3_kind == KIND_LOAD) && r3_lok && adv4;
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [PIX_W-1:0] r_bank_mem [BANK_DEPTH];
        logic [AW-1:0]    rd_addr;

        assign rd_addr = {row_for_par[b/2][RW-1:1], col_for_par[b%2][CW-1:1]};

        always_ff @(posedge i_clk) begin
            if (load_we && (load_bank == 2'(b))) begin
                r_bank_mem[load_addr] <= r3_pix;
            end
            if (adv4) begin
                r_bank_q[b] <= r_bank_mem[rd_addr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: bank data and weights for requests.
    logic          r4_r0p, r4_r1p, r4_c0p, r4_c1p;
    logic [WW-1:0] r4_w00, r4_w01, r4_w10, r4_w11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv4) begin
            r4_v <= r3_v && (r3_kind == KIND_PRODUCE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r4_r0p <= r3_r0[0];
            r4_r1p <= r3_r1[0];
            r4_c0p <= r3_c0[0];
            r4_c1p <= r3_c1[0];
            r4_w00 <= r3_w00;
            r4_w01 <= r3_w01;
            r4_w10 <= r3_w10;
            r4_w11 <= r3_w11;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: weighted sum per channel into the output register.
    logic [PIX_W-1:0]  px00, px01, px10, px11;
    logic [SW-1:0]     acc [3];
    logic [CHAN_W-1:0] chan [3];

    always_comb begin
        px00 = r_bank_q[{r4_r0p, r4_c0p}];
        px01 = r_bank_q[{r4_r0p, r4_c1p}];
        px10 = r_bank_q[{r4_r1p, r4_c0p}];
        px11 = r_bank_q[{r4_r1p, r4_c1p}];
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = SW'(px00[ch*CHAN_W +: CHAN_W] * r4_w00)
                    + SW'(px01[ch*CHAN_W +: CHAN_W] * r4_w01)
                    + SW'(px10[ch*CHAN_W +: CHAN_W] * r4_w10)
                    + SW'(px11[ch*CHAN_W +: CHAN_W] * r4_w11);
            // The weights never sum above one; saturate anyway.
            if (acc[ch][SW-1:FRAC_BITS+CHAN_W] != '0) begin
                chan[ch] = '1;
            end else begin
                chan[ch] = acc[ch][FRAC_BITS+CHAN_W-1:FRAC_BITS];
            end
        end
    end

    t_out_word r5_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv5) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv5) begin
            r5_word.out_blue  <= chan[0];
            r5_word.out_green <= chan[1];
            r5_word.out_red   <= chan[2];
        end
    end

    assign o_out.valid = r5_v;
    assign o_out.data  = r5_word;

endmodule

`default_nettype wire
